/* hw/rtl/qdp_pkg.sv */
// ----------------------------------------------------------------------------
// qdp_pkg
// Shared types and constants for the quadrature detent position block.
// ----------------------------------------------------------------------------
package qdp_pkg;

    localparam int unsigned POS_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned S_TDATA_W  = 24;
    localparam int unsigned M_TDATA_W  = 16;

    localparam logic [POS_W-1:0] POSITION_MIN_RST = 16'd0;
    localparam logic [POS_W-1:0] POSITION_MAX_RST = 16'd65535;
    localparam logic [POS_W-1:0] STEP_SIZE_RST    = 16'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE    = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_CW1  = 3'd1,
        PH_CW2  = 3'd2,
        PH_CW3  = 3'd3,
        PH_CCW1 = 3'd4,
        PH_CCW2 = 3'd5,
        PH_CCW3 = 3'd6
    } phase_t;

    typedef struct packed {
        logic cw;
        logic ccw;
    } detent_t;

endpackage

/* hw/rtl/qdp_phase_fsm.sv */
// ----------------------------------------------------------------------------
// qdp_phase_fsm
// Seven-phase quadrature tracker; flags a completed detent on the current item.
// ----------------------------------------------------------------------------
module qdp_phase_fsm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  logic            pin_a,
    input  logic            pin_b,
    output qdp_pkg::phase_t phase,
    output qdp_pkg::detent_t detent
);
    import qdp_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_CW1:
            begin
                if (!pin_a && !pin_b)
                    phase_next = PH_CW2;
                else if (pin_a && pin_b)
                    phase_next = PH_IDLE;
            end
            PH_CW2:
            begin
                if (!pin_a && pin_b)
                    phase_next = PH_CW3;
                else if (pin_a && !pin_b)
                    phase_next = PH_CW1;
                else if (pin_a && pin_b)
                    phase_next = PH_IDLE;
            end
            PH_CW3:
            begin
                if (!pin_a && !pin_b)
                    phase_next = PH_CW2;
                else if (pin_a && pin_b)
                    phase_next = PH_IDLE;
            end
            PH_CCW1:
            begin
                if (!pin_a && !pin_b)
                    phase_next = PH_CCW2;
                else if (pin_a && pin_b)
                    phase_next = PH_IDLE;
            end
            PH_CCW2:
            begin
                if (pin_a && !pin_b)
                    phase_next = PH_CCW3;
                else if (!pin_a && pin_b)
                    phase_next = PH_CCW1;
                else if (pin_a && pin_b)
                    phase_next = PH_IDLE;
            end
            PH_CCW3:
            begin
                if (!pin_a && !pin_b)
                    phase_next = PH_CCW2;
                else if (pin_a && pin_b)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                if (pin_a && !pin_b)
                    phase_next = PH_CW1;
                else if (!pin_a && pin_b)
                    phase_next = PH_CCW1;
                else
                    phase_next = PH_IDLE;
            end
        endcase
    end

    // detent flags
    always_comb
    begin
        detent = '0;
        case (phase_reg)
            PH_CW3:  detent.cw  = pin_a && pin_b;
            PH_CCW3: detent.ccw = pin_a && pin_b;
            default: detent     = '0;
        endcase
    end

    assign phase = phase_reg;

endmodule

/* hw/rtl/qdp_position_update.sv */
// ----------------------------------------------------------------------------
// qdp_position_update
// Adds or subtracts one step on a detent and clamps to the configured bounds.
// ----------------------------------------------------------------------------
module qdp_position_update (
    input  qdp_pkg::detent_t               detent,
    input  logic [qdp_pkg::POS_W-1:0]      position_in,
    input  logic [qdp_pkg::POS_W-1:0]      position_min,
    input  logic [qdp_pkg::POS_W-1:0]      position_max,
    input  logic [qdp_pkg::POS_W-1:0]      step_size,
    output logic [qdp_pkg::POS_W-1:0]      position_out
);
    import qdp_pkg::*;

    logic        [POS_W:0] sum;
    logic signed [POS_W:0] diff;
    logic signed [POS_W:0] min_s;

    assign sum   = {1'b0, position_in} + {1'b0, step_size};
    assign diff  = $signed({1'b0, position_in}) - $signed({1'b0, step_size});
    assign min_s = $signed({1'b0, position_min});

    always_comb
    begin
        position_out = position_in;
        if (detent.cw && (position_in < position_max))
        begin
            if (sum > {1'b0, position_max})
                position_out = position_max;
            else
                position_out = sum[POS_W-1:0];
        end
        else if (detent.ccw && (position_in > position_min))
        begin
            if (diff < min_s)
                position_out = position_min;
            else
                position_out = diff[POS_W-1:0];
        end
    end

endmodule

/* hw/rtl/quadrature_detent_position.sv */
// ----------------------------------------------------------------------------
// quadrature_detent_position
// Quadrature encoder decoder that moves a position by one step per detent.
//
//   channel  dir  width  contents
//   s_*      in   24     pin_a, pin_b, position_in
//   m_*      out  16     position_out
//   cfg_*    in   16     position_min, position_max, step_size
//
// one item per cycle while the output is not stalled: input register, then result register
// the phase register advances as an item moves into the result register
// reset returns the tracker to idle and loads the register defaults
// s_tready falls only while both registers hold items and m_tready is low
// ----------------------------------------------------------------------------
module quadrature_detent_position (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] pin_a, [1] pin_b, [17:2] position_in, [23:18] zero
    input  logic [qdp_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] position_out
    output logic [qdp_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_we,
    input  logic [qdp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qdp_pkg::POS_W-1:0]      cfg_data
);
    import qdp_pkg::*;

    logic [POS_W-1:0] position_min_reg;
    logic [POS_W-1:0] position_max_reg;
    logic [POS_W-1:0] step_size_reg;

    logic             in_valid_reg;
    logic             pin_a_reg;
    logic             pin_b_reg;
    logic [POS_W-1:0] position_in_reg;

    logic             out_valid_reg;
    logic [POS_W-1:0] position_out_reg;
    logic [POS_W-1:0] position_out_next;

    logic             advance;
    logic             step_en;
    phase_t           phase;
    detent_t          detent;

    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_min_reg <= POSITION_MIN_RST;
            position_max_reg <= POSITION_MAX_RST;
            step_size_reg    <= STEP_SIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POSITION_MIN: position_min_reg <= cfg_data;
                CFG_POSITION_MAX: position_max_reg <= cfg_data;
                CFG_STEP_SIZE:    step_size_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            pin_a_reg       <= s_tdata[0];
            pin_b_reg       <= s_tdata[1];
            position_in_reg <= s_tdata[POS_W+1:2];
        end
    end

    qdp_phase_fsm u_phase_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .pin_a   (pin_a_reg),
        .pin_b   (pin_b_reg),
        .phase   (phase),
        .detent  (detent)
    );

    qdp_position_update u_position_update (
        .detent       (detent),
        .position_in  (position_in_reg),
        .position_min (position_min_reg),
        .position_max (position_max_reg),
        .step_size    (step_size_reg),
        .position_out (position_out_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            position_out_reg <= position_out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = position_out_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    a_detent_needs_both_high: assert property (@(posedge clk) disable iff (!rst_n)
        (detent.cw || detent.ccw) |-> (pin_a_reg && pin_b_reg &&
            (phase == PH_CW3 || phase == PH_CCW3)))
        else $error("detent flagged outside a final phase");

    a_no_detent_passes_through: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && !detent.cw && !detent.ccw) |=> (m_tdata == $past(position_in_reg)))
        else $error("position changed without a detent");

    a_cw_never_decreases: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && detent.cw) |=> (m_tdata >= $past(position_in_reg)
            || $past(position_in_reg) >= $past(position_max_reg)))
        else $error("clockwise detent lowered the position");

endmodule

/* verif/quadrature_detent_position_test.sv */
// ----------------------------------------------------------------------------
// quadrature_detent_position_test
// Self-checking bench for the quadrature detent position block. Contact pairs
// and positions are streamed in, and each position out is compared with a
// prediction that tracks the detent phase and applies the clamped step.
// Register settings range over defaults, extremes, inverted bounds and random
// values. Both sides idle at random, and the output is held off for a long
// stretch so that the input stalls.
// ----------------------------------------------------------------------------
module quadrature_detent_position_test;

    timeunit 1ns;
    timeprecision 1ps;

    import qdp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    class position_scoreboard;
        logic [POS_W-1:0] pos_min;
        logic [POS_W-1:0] pos_max;
        logic [POS_W-1:0] step;
        phase_t           phase;
        logic [POS_W-1:0] expected_positions[$];
        int               errors;

        function new();
            pos_min = POSITION_MIN_RST;
            pos_max = POSITION_MAX_RST;
            step    = STEP_SIZE_RST;
            phase   = PH_IDLE;
            errors  = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] value);
            case (idx)
                CFG_POSITION_MIN: pos_min = value;
                CFG_POSITION_MAX: pos_max = value;
                CFG_STEP_SIZE:    step    = value;
                default:          ;
            endcase
        endfunction

        // advance the detent tracker and queue the position it yields
        function void note_sample(logic a, logic b, logic [POS_W-1:0] pos);
            logic [POS_W-1:0] res;
            logic [POS_W:0]   sum;
            int               diff;
            phase_t           nxt;
            res = pos;
            nxt = phase;
            case (phase)
                PH_CW1:
                begin
                    if (!a && !b) nxt = PH_CW2;
                    else if (a && b) nxt = PH_IDLE;
                end
                PH_CW2:
                begin
                    if (!a && b) nxt = PH_CW3;
                    else if (a && !b) nxt = PH_CW1;
                    else if (a && b) nxt = PH_IDLE;
                end
                PH_CW3:
                begin
                    if (!a && !b) nxt = PH_CW2;
                    else if (a && b)
                    begin
                        if (pos < pos_max)
                        begin
                            sum = {1'b0, pos} + {1'b0, step};
                            res = (sum > {1'b0, pos_max}) ? pos_max : sum[POS_W-1:0];
                        end
                        nxt = PH_IDLE;
                    end
                end
                PH_CCW1:
                begin
                    if (!a && !b) nxt = PH_CCW2;
                    else if (a && b) nxt = PH_IDLE;
                end
                PH_CCW2:
                begin
                    if (a && !b) nxt = PH_CCW3;
                    else if (!a && b) nxt = PH_CCW1;
                    else if (a && b) nxt = PH_IDLE;
                end
                PH_CCW3:
                begin
                    if (!a && !b) nxt = PH_CCW2;
                    else if (a && b)
                    begin
                        if (pos > pos_min)
                        begin
                            diff = int'(pos) - int'(step);
                            res = (diff < int'(pos_min)) ? pos_min : diff[POS_W-1:0];
                        end
                        nxt = PH_IDLE;
                    end
                end
                default:
                begin
                    if (a && !b) nxt = PH_CW1;
                    else if (!a && b) nxt = PH_CCW1;
                    else nxt = PH_IDLE;
                end
            endcase
            phase = nxt;
            expected_positions.push_back(res);
        endfunction

        function void check_position(logic [POS_W-1:0] actual);
            logic [POS_W-1:0] want;
            if (expected_positions.size() == 0)
            begin
                $display("%0t ns: position_out expected none, actual %0d", $time, actual);
                errors++;
                return;
            end
            want = expected_positions.pop_front();
            if (actual !== want)
            begin
                $display("%0t ns: position_out expected %0d, actual %0d", $time, want, actual);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [POS_W-1:0]      cfg_data  = '0;

    position_scoreboard board = new();
    int  items_sent = 0;
    bit  idle_off   = 1'b0;
    bit  long_hold  = 1'b0;

    quadrature_detent_position dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random stalls, plus one long hold on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready) board.check_position(m_tdata);
            if (stall_left > 0) stall_left--;
            else if (long_hold)
            begin
                stall_left = 200;
                long_hold  = 1'b0;
            end
            else if (!idle_off && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 18);
            m_tready <= (stall_left == 0);
        end
    end

    task automatic send_sample(logic a, logic b, logic [POS_W-1:0] pos);
        if (!idle_off && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-POS_W-2){1'b0}}, pos, b, a};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_sample(a, b, pos);
        items_sent++;
    endtask

    // one detent as {a,b} pairs, with optional bounce, repeated samples and abort
    task automatic send_detent(bit cw, logic [POS_W-1:0] pos, int bounce_pct, int hold_max,
                               int abort_at);
        logic [1:0] seq [4];
        if (cw) seq = '{2'b10, 2'b00, 2'b01, 2'b11};
        else    seq = '{2'b01, 2'b00, 2'b10, 2'b11};
        for (int k = 0; k < 4; k++)
        begin
            if (k == 3 && abort_at >= 0) break;
            repeat ($urandom_range(1, hold_max)) send_sample(seq[k][1], seq[k][0], pos);
            if (k == abort_at)
            begin
                send_sample(1'b1, 1'b1, pos);
                return;
            end
            if ((k == 1 || k == 2) && $urandom_range(1, 100) <= bounce_pct)
            begin
                send_sample(seq[k-1][1], seq[k-1][0], pos);
                send_sample(seq[k][1], seq[k][0], pos);
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.expected_positions.size() != 0) @(posedge clk);
    endtask

    task automatic write_one(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        board.set_register(idx, value);
    endtask

    task automatic write_registers(logic [POS_W-1:0] lo, logic [POS_W-1:0] hi,
                                   logic [POS_W-1:0] stp);
        wait_drained();
        write_one(CFG_POSITION_MIN, lo);
        write_one(CFG_POSITION_MAX, hi);
        write_one(CFG_STEP_SIZE, stp);
        write_one(CFG_UNUSED, 16'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [POS_W-1:0] pick_position();
        logic [POS_W-1:0] near;
        near = 16'($urandom_range(0, 3));
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return board.pos_min + near;
            3:       return board.pos_min - near;
            4:       return board.pos_max + near;
            5:       return board.pos_max - near;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [POS_W-1:0] lo, hi, stp;
        int               phase_start;
        int               r;
        bit               paused;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults straight after reset
        send_detent(1'b1, 16'd0, 0, 1, -1);
        send_detent(1'b0, 16'd0, 0, 1, -1);
        send_detent(1'b1, 16'hFFFF, 0, 1, -1);

        // overflow and underflow clamps, bounce, illegal pair
        write_registers(16'd100, 16'd60000, 16'd40000);
        send_detent(1'b1, 16'd50000, 100, 1, -1);
        send_detent(1'b0, 16'd20000, 0, 1, -1);
        send_detent(1'b1, 16'd12345, 0, 1, 0);

        for (int p = 0; p < 9; p++)
        begin
            case (p)
                0:       begin lo = 16'd0;     hi = 16'hFFFF; stp = 16'd1;     end
                1:       begin lo = 16'd0;     hi = 16'hFFFF; stp = 16'd0;     end
                2:       begin lo = 16'hFFFF;  hi = 16'd0;    stp = 16'hFFFF;  end
                3:       begin lo = 16'd1000;  hi = 16'd2000; stp = 16'hFFFF;  end
                4:       begin lo = 16'd0;     hi = 16'hFFFF; stp = 16'hFFFF;  end
                default:
                begin
                    lo  = 16'($urandom);
                    hi  = 16'($urandom);
                    stp = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 64));
                end
            endcase
            write_registers(lo, hi, stp);
            idle_off    = (p == 6 || p == 8);
            phase_start = items_sent;
            paused      = 1'b0;
            if (p == 2)
            begin
                // long output hold while items keep coming
                long_hold = 1'b1;
                repeat (12) send_sample(1'($urandom), 1'($urandom), 16'($urandom));
            end
            while (items_sent < phase_start + 38)
            begin
                if (p == 4 && !paused && items_sent >= phase_start + 20)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 9);
                if (r < 7)
                    send_detent(1'($urandom), pick_position(), 20, 3, -1);
                else if (r == 7)
                    send_detent(1'($urandom), pick_position(), 20, 2, $urandom_range(0, 1));
                else
                    repeat ($urandom_range(1, 4))
                        send_sample(1'($urandom), 1'($urandom), 16'($urandom));
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* quadrature_detent_position.f */
hw/rtl/qdp_pkg.sv
hw/rtl/qdp_phase_fsm.sv
hw/rtl/qdp_position_update.sv
hw/rtl/quadrature_detent_position.sv
verif/quadrature_detent_position_test.sv
